@@ design/cpenc_pkg.sv @@
// Shared types and constants for the codepoint to UTF byte encoder.
`default_nettype none

package cpenc_pkg;

  typedef enum logic [1:0] {
    MODE_OCTET   = 2'd0,
    MODE_UTF8    = 2'd1,
    MODE_UTF16BE = 2'd2,
    MODE_UTF16LE = 2'd3
  } enc_mode_t;

  localparam int unsigned CP_W = 21;

  // One encoded codepoint: up to four bytes in stream order.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            err;
  } enc_entry_t;

endpackage

`default_nettype wire

@@ design/cpenc_front.sv @@
// Front end: mode register, input handshake and codepoint classification.
`default_nettype none

module cpenc_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  input  wire logic [1:0]                cfg_encoding_mode,
  input  wire logic                      in_valid,
  input  wire logic [cpenc_pkg::CP_W-1:0] in_codepoint,
  output logic                           in_stall,
  input  wire logic                      q_full,
  output logic                           q_push,
  output cpenc_pkg::enc_entry_t          q_entry
);
  import cpenc_pkg::*;

  enc_mode_t       mode_r;
  logic [CP_W-1:0] u;
  logic [CP_W-1:0] diff;
  logic [19:0]     v;
  logic            little;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_UTF8;
    end else if (cfg_valid) begin
      mode_r <= enc_mode_t'(cfg_encoding_mode);
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign u      = in_codepoint;
  assign diff   = u - CP_W'(21'h10000);
  assign v      = diff[19:0];
  assign little = (mode_r == MODE_UTF16LE);

  always_comb begin
    q_entry = '0;
    unique case (mode_r)
      MODE_OCTET: begin
        q_entry.bytes[0] = u[7:0];
        q_entry.err      = (u[CP_W-1:8] != '0);
        q_entry.last_idx = 2'd0;
      end
      MODE_UTF8: begin
        priority if (u <= CP_W'(21'h7F)) begin
          q_entry.bytes[0] = u[7:0];
          q_entry.last_idx = 2'd0;
        end else if (u <= CP_W'(21'h7FF)) begin
          q_entry.bytes[0] = 8'hC0 | {3'b000, u[10:6]};
          q_entry.bytes[1] = 8'h80 | {2'b00, u[5:0]};
          q_entry.last_idx = 2'd1;
        end else if (u <= CP_W'(21'hFFFF)) begin
          q_entry.bytes[0] = 8'hE0 | {4'b0000, u[15:12]};
          q_entry.bytes[1] = 8'h80 | {2'b00, u[11:6]};
          q_entry.bytes[2] = 8'h80 | {2'b00, u[5:0]};
          q_entry.last_idx = 2'd2;
        end else begin
          q_entry.bytes[0] = 8'hF0 | {5'b00000, u[20:18]};
          q_entry.bytes[1] = 8'h80 | {2'b00, u[17:12]};
          q_entry.bytes[2] = 8'h80 | {2'b00, u[11:6]};
          q_entry.bytes[3] = 8'h80 | {2'b00, u[5:0]};
          q_entry.last_idx = 2'd3;
        end
      end
      MODE_UTF16BE, MODE_UTF16LE: begin
        if (u <= CP_W'(21'hFFFF)) begin
          q_entry.bytes[0] = little ? u[7:0]  : u[15:8];
          q_entry.bytes[1] = little ? u[15:8] : u[7:0];
          q_entry.last_idx = 2'd1;
        end else begin
          // surrogate pair; bit 20 of the offset value is dropped
          q_entry.bytes[0] = little ? v[17:10] : (8'hD8 | {6'd0, v[19:18]});
          q_entry.bytes[1] = little ? (8'hD8 | {6'd0, v[19:18]}) : v[17:10];
          q_entry.bytes[2] = little ? v[7:0] : (8'hDC | {6'd0, v[9:8]});
          q_entry.bytes[3] = little ? (8'hDC | {6'd0, v[9:8]}) : v[7:0];
          q_entry.last_idx = 2'd3;
        end
      end
      default: begin
        q_entry = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/cpenc_fifo.sv @@
// Short queue of encoded entries between front and back end.
`default_nettype none

module cpenc_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  cpenc_pkg::enc_entry_t      push_entry,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       head_valid,
  output cpenc_pkg::enc_entry_t      head
);
  import cpenc_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  enc_entry_t          mem_r [DEPTH];
  logic [PW-1:0]       wr_ptr_r;
  logic [PW-1:0]       rd_ptr_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full) |-> pop)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

@@ design/cpenc_back.sv @@
// Back end: walks the head entry one byte per beat into the output register.
`default_nettype none

module cpenc_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  head_valid,
  input  cpenc_pkg::enc_entry_t      head,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_byte,
  output logic [1:0]                 out_byte_index,
  output logic                       out_last_byte,
  output logic                       out_range_error
);
  import cpenc_pkg::*;

  logic [1:0] k_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic [1:0] out_idx_r;
  logic       out_last_r;
  logic       out_err_r;
  logic       slot_free;
  logic       load;
  logic       is_last;

  assign slot_free = !out_valid_r || !out_stall;
  assign load      = head_valid && slot_free;
  assign is_last   = (k_r == head.last_idx);
  assign pop       = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid_r <= head_valid;
      end
      if (load) begin
        k_r <= is_last ? 2'd0 : k_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= head.bytes[k_r];
      out_idx_r  <= k_r;
      out_last_r <= is_last;
      out_err_r  <= head.err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_byte_index  = out_idx_r;
  assign out_last_byte   = out_last_r;
  assign out_range_error = out_err_r;

  // mid-entry the head must stay in the queue
  a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r != 2'd0) |-> head_valid)
    else $error("head entry lost in the middle of a codepoint");

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_last_r && out_idx_r == 2'd0))
    else $error("range error on a multi-byte encoding");

endmodule

`default_nettype wire

@@ design/codepoint_to_utf_bytes.sv @@
// Top level of the codepoint to UTF-8 / UTF-16 / octet byte encoder.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_codepoint[20:0]
//   out_     output     out_valid / out_stall out_byte, out_byte_index,
//                                              out_last_byte, out_range_error
//   cfg_     input      cfg_valid / cfg_ready cfg_encoding_mode[1:0]
//
// One output beat per cycle while the queue holds data and out_stall is low;
// a codepoint gives 1 to 4 bytes, which the back end emits one per beat.
// The front end classifies a codepoint in the cycle it is accepted and drops
// it in a QUEUE_DEPTH-entry queue; input stalls only when that queue is full.
// The first byte of a codepoint passes the queue, then the output register, to out_.
// Synchronous active-low reset empties the queue and output register and sets
// the mode to UTF-8. cfg_ready is always high.
`default_nettype none

module codepoint_to_utf_bytes #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_encoding_mode,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [cpenc_pkg::CP_W-1:0] in_codepoint,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_byte,
  output logic [1:0]                     out_byte_index,
  output logic                           out_last_byte,
  output logic                           out_range_error
);
  import cpenc_pkg::*;

  enc_entry_t q_entry;
  enc_entry_t q_head;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_head_valid;

  // the user must issue mode writes only while idle (the block does not enforce it); they are always taken
  assign cfg_ready = 1'b1;

  cpenc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_encoding_mode (cfg_encoding_mode),
    .in_valid          (in_valid),
    .in_codepoint      (in_codepoint),
    .in_stall          (in_stall),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_entry           (q_entry)
  );

  cpenc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // back end owns the output register, so out_valid is registered and does not depend combinationally on out_stall
  cpenc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head            (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_index  (out_byte_index),
    .out_last_byte   (out_last_byte),
    .out_range_error (out_range_error)
  );

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the codepoint to UTF byte encoder.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cpenc_pkg::*;

  // One expected output beat: a single encoded byte and its tags.
  typedef struct {
    logic [7:0] data;
    logic [1:0] idx;
    logic       last;
    logic       err;
  } enc_beat_t;

  // Receiver back-pressure styles.
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_style_t;

  localparam int HOLD_CYCLES   = 100;
  localparam int HOLD_AFTER    = 300;
  localparam int MAX_PRINTED   = 20;
  localparam int ITEMS_PER_SET = 17;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [1:0]          cfg_encoding_mode = 2'd0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [CP_W-1:0]     in_codepoint = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [7:0]          out_byte;
  logic [1:0]          out_byte_index;
  logic                out_last_byte;
  logic                out_range_error;

  // Codepoints waiting for the input driver, and bytes waiting for the output.
  logic [CP_W-1:0] codepoint_q[$];
  enc_beat_t       enc_bytes_q[$];

  enc_mode_t    mode_shadow;
  int           n_fail = 0;
  int           n_bytes_ok = 0;
  int           n_err_bytes = 0;
  int           n_cfg_writes = 0;
  int           cp_per_mode[4] = '{0, 0, 0, 0};
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_cycle = 0;
  int           hold_left = 0;
  bit           hold_done = 1'b0;
  int           style_left = 0;
  stall_style_t stall_style = STALL_NONE;

  codepoint_to_utf_bytes u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_encoding_mode(cfg_encoding_mode),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_codepoint     (in_codepoint),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_byte_index   (out_byte_index),
    .out_last_byte    (out_last_byte),
    .out_range_error  (out_range_error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (n_fail < MAX_PRINTED) $display("MISMATCH at %0t ns: %s", $time, msg);
    n_fail++;
  endtask

  // Expected byte stream of one codepoint under the given mode.
  function automatic void predict_bytes(logic [CP_W-1:0] cp, enc_mode_t mode);
    logic [7:0]  b[4];
    int          n;
    logic        err;
    logic [19:0] v;
    logic [7:0]  h_hi, h_lo, l_hi, l_lo;
    enc_beat_t   beat;
    err = 1'b0;
    n = 0;
    case (mode)
      MODE_OCTET: begin
        b[0] = cp[7:0];
        err = (cp > 21'h0000FF);
        n = 1;
      end
      MODE_UTF8: begin
        if (cp <= 21'h00007F) begin
          b[0] = cp[7:0];
          n = 1;
        end else if (cp <= 21'h0007FF) begin
          b[0] = 8'hC0 | {3'b000, cp[10:6]};
          b[1] = 8'h80 | {2'b00, cp[5:0]};
          n = 2;
        end else if (cp <= 21'h00FFFF) begin
          b[0] = 8'hE0 | {4'h0, cp[15:12]};
          b[1] = 8'h80 | {2'b00, cp[11:6]};
          b[2] = 8'h80 | {2'b00, cp[5:0]};
          n = 3;
        end else begin
          b[0] = 8'hF0 | {5'b00000, cp[20:18]};
          b[1] = 8'h80 | {2'b00, cp[17:12]};
          b[2] = 8'h80 | {2'b00, cp[11:6]};
          b[3] = 8'h80 | {2'b00, cp[5:0]};
          n = 4;
        end
      end
      default: begin
        if (cp <= 21'h00FFFF) begin
          b[0] = (mode == MODE_UTF16LE) ? cp[7:0] : cp[15:8];
          b[1] = (mode == MODE_UTF16LE) ? cp[15:8] : cp[7:0];
          n = 2;
        end else begin
          // Above the Unicode range the 20-bit offset simply wraps.
          v    = 20'(cp - 21'h010000);
          h_hi = 8'hD8 | {6'b000000, v[19:18]};
          h_lo = v[17:10];
          l_hi = 8'hDC | {6'b000000, v[9:8]};
          l_lo = v[7:0];
          if (mode == MODE_UTF16LE) begin
            b[0] = h_lo; b[1] = h_hi; b[2] = l_lo; b[3] = l_hi;
          end else begin
            b[0] = h_hi; b[1] = h_lo; b[2] = l_hi; b[3] = l_lo;
          end
          n = 4;
        end
      end
    endcase
    for (int k = 0; k < n; k++) begin
      beat.data = b[k];
      beat.idx  = 2'(k);
      beat.last = (k == n - 1);
      beat.err  = err;
      enc_bytes_q.push_back(beat);
    end
  endfunction

  // Input driver: bursts of beats with random gaps; a stalled beat holds still.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (codepoint_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_codepoint <= codepoint_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          // a quarter of bursts run straight into the next one
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Receiver stall: random styles in stretches, plus one long hold-off while
  // the sender keeps offering, so the internal queue fills and in_stall rises.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_cycle = 0;
    end else begin
      stall_cycle++;
      if (!hold_done && stall_cycle >= HOLD_AFTER && in_valid) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (style_left == 0) begin
          stall_style = stall_style_t'($urandom_range(0, 3));
          style_left = $urandom_range(8, 48);
        end
        style_left--;
        case (stall_style)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
          default:     out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // Monitor: tracks the mode register, predicts on each accepted codepoint
  // and checks each accepted byte against the oldest prediction.
  always @(posedge clk) begin : monitor
    enc_beat_t want;
    if (!rst_n) begin
      mode_shadow = MODE_UTF8;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_shadow = enc_mode_t'(cfg_encoding_mode);
        n_cfg_writes++;
      end
      // Output first, so a stray byte is never matched against a fresh entry.
      if (out_valid && !out_stall) begin
        if (enc_bytes_q.size() == 0) begin
          report_mismatch($sformatf("byte %02h idx %0d with nothing pending",
                                    out_byte, out_byte_index));
        end else begin
          want = enc_bytes_q.pop_front();
          if (out_byte !== want.data || out_byte_index !== want.idx ||
              out_last_byte !== want.last || out_range_error !== want.err) begin
            report_mismatch($sformatf(
              "got byte %02h idx %0d last %b err %b, want %02h idx %0d last %b err %b",
              out_byte, out_byte_index, out_last_byte, out_range_error,
              want.data, want.idx, want.last, want.err));
          end else begin
            n_bytes_ok++;
            if (want.err) n_err_bytes++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_bytes(in_codepoint, mode_shadow);
        cp_per_mode[mode_shadow]++;
      end
    end
  end

  // Everything sent, nothing in flight, plus a few cycles of margin.
  task automatic wait_idle();
    @(negedge clk);
    while (codepoint_q.size() != 0 || in_valid || enc_bytes_q.size() != 0)
      @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_mode(enc_mode_t mode);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_encoding_mode <= mode;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    wait_idle();
  endtask

  // Random codepoint, weighted toward encoding-length boundaries.
  function automatic logic [CP_W-1:0] pick_codepoint();
    case ($urandom_range(0, 9))
      0:       return CP_W'($urandom_range(0, 'h7F));
      1:       return CP_W'($urandom_range('h80, 'h7FF));
      2:       return CP_W'($urandom_range('h800, 'hFFFF));
      3:       return CP_W'($urandom_range('hD800, 'hDFFF));
      4:       return CP_W'($urandom_range('h10000, 'h10FFFF));
      5:       return CP_W'($urandom_range('h110000, 'h1FFFFF));
      6:       return CP_W'($urandom_range(0, 'hFF));
      7: begin
        // just either side of a threshold
        case ($urandom_range(0, 3))
          0:       return CP_W'('h7F + $urandom_range(0, 1));
          1:       return CP_W'('h7FF + $urandom_range(0, 1));
          2:       return CP_W'('hFFFF + $urandom_range(0, 1));
          default: return CP_W'('hFF + $urandom_range(0, 1));
        endcase
      end
      default: return CP_W'($urandom());
    endcase
  endfunction

  task automatic send_list(logic [CP_W-1:0] cps[]);
    @(negedge clk);
    foreach (cps[i]) codepoint_q.push_back(cps[i]);
    wait_idle();
  endtask

  initial begin : stimulus
    enc_mode_t phase_modes[8];
    logic [CP_W-1:0] burst[];
    phase_modes = '{MODE_OCTET, MODE_UTF16LE, MODE_UTF8, MODE_UTF16BE,
                    MODE_UTF16LE, MODE_OCTET, MODE_UTF8, MODE_UTF16BE};

    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: UTF-8 straight out of reset, no register write yet.
    send_list('{21'h000000, 21'h00007F, 21'h000080, 21'h0007FF, 21'h000800,
                21'h00D800, 21'h00FFFF, 21'h010000, 21'h10FFFF, 21'h1FFFFF});
    // Octet: boundary, overflow by one, and the widest value.
    write_mode(MODE_OCTET);
    send_list('{21'h0000FF, 21'h000100, 21'h1FFFFF, 21'h000000, 21'h000080});
    // UTF-16 both orders: single unit edge, surrogate pair, wrap above Unicode.
    write_mode(MODE_UTF16BE);
    send_list('{21'h00FFFF, 21'h010000, 21'h10FFFF, 21'h110000, 21'h1FFFFF});
    write_mode(MODE_UTF16LE);
    send_list('{21'h00DFFF, 21'h010000, 21'h10FFFF, 21'h110000, 21'h1FFFFF});

    // Random phases, mode changed only between them.
    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      burst = new[ITEMS_PER_SET];
      foreach (burst[i]) burst[i] = pick_codepoint();
      send_list(burst);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (enc_bytes_q.size() != 0)
      report_mismatch($sformatf("%0d bytes never came out", enc_bytes_q.size()));

    $display("Encoded %0d octet, %0d UTF-8, %0d UTF-16BE, %0d UTF-16LE codepoints",
             cp_per_mode[MODE_OCTET], cp_per_mode[MODE_UTF8],
             cp_per_mode[MODE_UTF16BE], cp_per_mode[MODE_UTF16LE]);
    $display("%0d bytes matched (%0d flagged out of range), %0d mode writes, long hold %s",
             n_bytes_ok, n_err_bytes, n_cfg_writes, hold_done ? "applied" : "missed");
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d bytes outstanding", enc_bytes_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
design/cpenc_pkg.sv
design/cpenc_front.sv
design/cpenc_fifo.sv
design/cpenc_back.sv
design/codepoint_to_utf_bytes.sv
dv/tb.sv
